/* hdl/rrpqs_pkg.sv */
// ----------------------------------------------------------------------------
// rrpqs_pkg
// shared types, codes and sizes for the ready queue scheduler
// ----------------------------------------------------------------------------
package rrpqs_pkg;

  localparam int READY_DEPTH = 64;
  localparam int WAIT_DEPTH  = 64;
  localparam int ID_BITS     = 16;
  localparam int PRIO_BITS   = 7;
  localparam int CNT_BITS    = 7;
  localparam int RIDX_BITS   = $clog2(READY_DEPTH);
  localparam int WIDX_BITS   = $clog2(WAIT_DEPTH);
  localparam int FQ_DEPTH    = 2;

  localparam logic [15:0] QUANTUM_RESET = 16'd500;

  localparam logic [2:0] OP_ARRIVE   = 3'd0;
  localparam logic [2:0] OP_DISPATCH = 3'd1;
  localparam logic [2:0] OP_TICK     = 3'd2;
  localparam logic [2:0] OP_IO_REQ   = 3'd3;
  localparam logic [2:0] OP_IO_DONE  = 3'd4;
  localparam logic [2:0] OP_TERM     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISP     = 3'd1;
  localparam logic [2:0] ST_PREEMPT  = 3'd2;
  localparam logic [2:0] ST_NOTHING  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] task_id;
    logic [6:0]  task_priority;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_task_id;
    logic [6:0]  out_priority;
    logic [6:0]  ready_count;
    logic [6:0]  waiting_count;
    logic        running_valid;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } task_t;

  // classified event handed from the front to the back
  typedef struct packed {
    logic         valid_op;
    logic [2:0]   opcode;
    task_t        tsk;
  } evt_t;

endpackage

/* hdl/rrpqs_front.sv */
// ----------------------------------------------------------------------------
// rrpqs_front
// accepts events, decodes them and queues them for the back end
// ----------------------------------------------------------------------------
module rrpqs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rrpqs_pkg::in_item_t in_item,
  output logic                evt_valid,
  output rrpqs_pkg::evt_t     evt,
  input  logic                evt_take
);

  rrpqs_pkg::evt_t q_r [rrpqs_pkg::FQ_DEPTH];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  rrpqs_pkg::evt_t cls;

  assign busy = (cnt_r == 2'(rrpqs_pkg::FQ_DEPTH));
  assign push = start && !busy;

  always_comb begin
    cls.opcode   = in_item.opcode;
    cls.valid_op = (in_item.opcode <= rrpqs_pkg::OP_TERM);
    cls.tsk.id   = in_item.task_id[rrpqs_pkg::ID_BITS-1:0];
    cls.tsk.prio = in_item.task_priority;
  end

  assign evt_valid = (cnt_r != 2'd0);
  assign evt       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = evt_take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(evt_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

/* hdl/rrpqs_back.sv */
// ----------------------------------------------------------------------------
// rrpqs_back
// executes events on the ready queue, waiting list and running slot
// ----------------------------------------------------------------------------
module rrpqs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 evt_valid,
  input  rrpqs_pkg::evt_t      evt,
  output logic                 evt_take,
  input  logic                 sched_mode,
  input  logic [15:0]          quantum_ticks,
  output logic                 out_valid,
  output rrpqs_pkg::out_item_t out_item
);

  localparam int RD = rrpqs_pkg::READY_DEPTH;
  localparam int WD = rrpqs_pkg::WAIT_DEPTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;

  rrpqs_pkg::task_t rq_r [RD];
  rrpqs_pkg::task_t wq_r [WD];
  logic [rrpqs_pkg::CNT_BITS-1:0] rfill_r, wfill_r;
  rrpqs_pkg::task_t run_r;
  logic             run_v_r;
  logic [15:0]      tick_r;
  logic [1:0]       st_r;
  rrpqs_pkg::evt_t  e_r;

  // registered search results over the cell rows
  logic [rrpqs_pkg::RIDX_BITS-1:0] pick_r;
  logic [rrpqs_pkg::WIDX_BITS-1:0] wpos_r;
  logic                            wfound_r;

  // min-select tree over the cells, heap order: node n has children 2n and 2n+1
  logic [rrpqs_pkg::RIDX_BITS-1:0] t_idx  [2*RD];
  logic [rrpqs_pkg::PRIO_BITS-1:0] t_prio [2*RD];
  logic                            t_ok   [2*RD];
  logic [rrpqs_pkg::WIDX_BITS-1:0] wpos_c;
  logic                            wfound_c;

  always_comb begin
    t_idx[0]  = '0;
    t_prio[0] = '0;
    t_ok[0]   = 1'b0;
    for (int i = 0; i < RD; i++) begin
      t_idx[RD+i]  = rrpqs_pkg::RIDX_BITS'(i);
      t_prio[RD+i] = rq_r[i].prio;
      t_ok[RD+i]   = (rrpqs_pkg::CNT_BITS'(i) < rfill_r);
    end
    for (int n = RD - 1; n >= 1; n--) begin
      // the later entry wins only on a strictly smaller value
      if (t_ok[2*n+1] && (!t_ok[2*n] || (t_prio[2*n+1] < t_prio[2*n]))) begin
        t_idx[n]  = t_idx[2*n+1];
        t_prio[n] = t_prio[2*n+1];
        t_ok[n]   = 1'b1;
      end else begin
        t_idx[n]  = t_idx[2*n];
        t_prio[n] = t_prio[2*n];
        t_ok[n]   = t_ok[2*n];
      end
    end
  end

  always_comb begin
    wfound_c = 1'b0;
    wpos_c   = '0;
    for (int i = WD - 1; i >= 0; i--) begin
      if ((rrpqs_pkg::CNT_BITS'(i) < wfill_r) && (wq_r[i].id == evt.tsk.id)) begin
        wfound_c = 1'b1;
        wpos_c   = rrpqs_pkg::WIDX_BITS'(i);
      end
    end
  end

  assign evt_take = (st_r == S_IDLE) && evt_valid;

  logic        rfull, wfull, expire;
  logic [15:0] nxt_tick;
  assign rfull    = (rfill_r >= rrpqs_pkg::CNT_BITS'(RD));
  assign wfull    = (wfill_r >= rrpqs_pkg::CNT_BITS'(WD));
  assign nxt_tick = (tick_r != 16'hFFFF) ? tick_r + 16'd1 : tick_r;
  assign expire   = (nxt_tick >= quantum_ticks);

  logic [2:0]       r_status;
  rrpqs_pkg::task_t r_task;
  logic             do_rpush, do_rtake, do_wpush, do_wtake, do_run, do_stop, tk_set;
  rrpqs_pkg::task_t rpush_val;

  always_comb begin
    r_status  = rrpqs_pkg::ST_NOTHING;
    r_task    = '0;
    do_rpush  = 1'b0;
    do_rtake  = 1'b0;
    do_wpush  = 1'b0;
    do_wtake  = 1'b0;
    do_run    = 1'b0;
    do_stop   = 1'b0;
    tk_set    = 1'b0;
    rpush_val = run_r;
    if (e_r.valid_op) begin
      unique case (e_r.opcode)
        rrpqs_pkg::OP_ARRIVE: begin
          r_task    = e_r.tsk;
          rpush_val = e_r.tsk;
          if (rfull) begin
            r_status = rrpqs_pkg::ST_FULL;
          end else begin
            r_status = rrpqs_pkg::ST_OK;
            do_rpush = 1'b1;
          end
        end
        rrpqs_pkg::OP_DISPATCH: begin
          if (!run_v_r && rfill_r != '0) begin
            r_status = rrpqs_pkg::ST_DISP;
            r_task   = rq_r[pick_r];
            do_rtake = 1'b1;
            do_run   = 1'b1;
          end
        end
        rrpqs_pkg::OP_TICK: begin
          if (run_v_r) begin
            r_task = run_r;
            if (expire) begin
              if (rfull) begin
                r_status = rrpqs_pkg::ST_FULL;
              end else begin
                r_status = rrpqs_pkg::ST_PREEMPT;
                do_rpush = 1'b1;
                do_stop  = 1'b1;
              end
            end else begin
              r_status = rrpqs_pkg::ST_OK;
              tk_set   = 1'b1;
            end
          end
        end
        rrpqs_pkg::OP_IO_REQ: begin
          if (run_v_r) begin
            r_task = run_r;
            if (wfull) begin
              r_status = rrpqs_pkg::ST_FULL;
            end else begin
              r_status = rrpqs_pkg::ST_OK;
              do_wpush = 1'b1;
              do_stop  = 1'b1;
            end
          end
        end
        rrpqs_pkg::OP_IO_DONE: begin
          if (!wfound_r) begin
            r_status = rrpqs_pkg::ST_NOTFOUND;
            r_task   = '{id: e_r.tsk.id, prio: '0};
          end else begin
            r_task    = wq_r[wpos_r];
            rpush_val = wq_r[wpos_r];
            if (rfull) begin
              r_status = rrpqs_pkg::ST_FULL;
            end else begin
              r_status = rrpqs_pkg::ST_OK;
              do_rpush = 1'b1;
              do_wtake = 1'b1;
            end
          end
        end
        rrpqs_pkg::OP_TERM: begin
          if (run_v_r) begin
            r_status = rrpqs_pkg::ST_OK;
            r_task   = run_r;
            do_stop  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  logic [rrpqs_pkg::CNT_BITS-1:0] rfill_nxt, wfill_nxt;
  assign rfill_nxt = rfill_r + rrpqs_pkg::CNT_BITS'(do_rpush) - rrpqs_pkg::CNT_BITS'(do_rtake);
  assign wfill_nxt = wfill_r + rrpqs_pkg::CNT_BITS'(do_wpush) - rrpqs_pkg::CNT_BITS'(do_wtake);

  logic exec;
  assign exec = (st_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      rfill_r   <= '0;
      wfill_r   <= '0;
      run_v_r   <= 1'b0;
      run_r     <= '0;
      tick_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= exec;
      unique case (st_r)
        S_IDLE: if (evt_valid) st_r <= S_EXEC;
        S_EXEC: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      if (exec) begin
        rfill_r <= rfill_nxt;
        wfill_r <= wfill_nxt;
        if (do_run) begin
          run_r   <= r_task;
          run_v_r <= 1'b1;
          tick_r  <= '0;
        end else if (do_stop) begin
          run_v_r <= 1'b0;
          tick_r  <= '0;
        end else if (tk_set) begin
          tick_r  <= nxt_tick;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      e_r      <= evt;
      pick_r   <= sched_mode ? t_idx[1] : '0;
      wpos_r   <= wpos_c;
      wfound_r <= wfound_c;
    end
    if (exec) begin
      out_item.status        <= r_status;
      out_item.out_task_id   <= 16'(r_task.id);
      out_item.out_priority  <= r_task.prio;
      out_item.ready_count   <= rfill_nxt;
      out_item.waiting_count <= wfill_nxt;
      out_item.running_valid <= do_run | (run_v_r & ~do_stop);
    end
  end

  // cell rows: close up behind the removed entry, append at the tail
  always_ff @(posedge clk) begin
    if (exec) begin
      for (int i = 0; i < RD - 1; i++) begin
        if (do_rtake && rrpqs_pkg::RIDX_BITS'(i) >= pick_r) begin
          rq_r[i] <= rq_r[i+1];
        end
      end
      for (int i = 0; i < RD; i++) begin
        if (do_rpush && rrpqs_pkg::CNT_BITS'(i) == rfill_r) begin
          rq_r[i] <= rpush_val;
        end
      end
      for (int i = 0; i < WD - 1; i++) begin
        if (do_wtake && rrpqs_pkg::WIDX_BITS'(i) >= wpos_r) begin
          wq_r[i] <= wq_r[i+1];
        end
      end
      for (int i = 0; i < WD; i++) begin
        if (do_wpush && rrpqs_pkg::CNT_BITS'(i) == wfill_r) begin
          wq_r[i] <= run_r;
        end
      end
    end
  end

endmodule

/* hdl/rr_priority_ready_queue_scheduler_top.sv */
// ----------------------------------------------------------------------------
// rr_priority_ready_queue_scheduler_top
// task scheduler with ready queue, i/o waiting list and one running slot
// ----------------------------------------------------------------------------
// an accepted event passes the front queue, the back end's search capture and
// execute state, then strobes its result; the back end takes one event at a
// time. the front queue holds two events; busy rises only when it is full.
// results cannot be stalled; synchronous reset empties both lists and the slot
module rr_priority_ready_queue_scheduler_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rrpqs_pkg::in_item_t  in_item,
  output logic                 out_strobe,
  output rrpqs_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);

  logic            sched_mode_r;
  logic [15:0]     quantum_r;
  logic            evt_valid, evt_take;
  rrpqs_pkg::evt_t evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_mode_r <= 1'b0;
      quantum_r    <= rrpqs_pkg::QUANTUM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrpqs_pkg::CFG_MODE:    sched_mode_r <= cfg_wdata[0];
        rrpqs_pkg::CFG_QUANTUM: quantum_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rrpqs_front u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .evt_valid, .evt, .evt_take
  );

  rrpqs_back u_back (
    .clk, .rst_n, .evt_valid, .evt, .evt_take,
    .sched_mode(sched_mode_r), .quantum_ticks(quantum_r),
    .out_valid(out_strobe), .out_item
  );

endmodule
